FILE: src/assert_macros.svh
// Assertion macros for the checker file ovn_chk.sv.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OVN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OVN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ovn_pkg.sv
// Package for the octave value noise block: sizes, codes, microcode word and program.
// No dependencies; used by octave_value_noise_2d and ovn_seq.
`default_nettype none

package ovn_pkg;

  localparam int GRID_SIZE     = 64;
  localparam int OCTAVE_COUNT  = 5;
  localparam int COORD_W       = $clog2(GRID_SIZE);
  localparam int ADDR_W        = 2 * COORD_W;
  localparam int DEPTH         = GRID_SIZE * GRID_SIZE;
  localparam int FRAC_W        = 16;
  localparam int VAL_W         = 16;
  localparam int WEIGHT_REGS   = 5;
  localparam int CFG_IDX_W     = $clog2(WEIGHT_REGS);
  localparam int OCT_W         = (OCTAVE_COUNT > 1) ? $clog2(OCTAVE_COUNT) : 1;
  localparam int ACC_W         = VAL_W + $clog2(OCTAVE_COUNT + 1);
  localparam int UCODE_LEN     = 7;
  localparam int STEP_W        = $clog2(UCODE_LEN);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [VAL_W-1:0] WEIGHT_RST [WEIGHT_REGS] = '{
    16'd7985, 16'd9982, 16'd12477, 16'd15596, 16'd19496
  };

  // Which corner the read port fetches.
  typedef enum logic [1:0] {
    CRN_00 = 2'd0,
    CRN_10 = 2'd1,
    CRN_01 = 2'd2,
    CRN_11 = 2'd3
  } corner_e;

  // What the shared multiply-add unit does in a step.
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_TOP  = 3'd1,
    MUL_BOT  = 3'd2,
    MUL_VERT = 3'd3,
    MUL_WGT  = 3'd4
  } mul_e;

  typedef enum logic {
    JMP_NEXT = 1'b0,
    JMP_OCT  = 1'b1
  } jmp_e;

  typedef struct packed {
    corner_e rd;
    logic    ld_s0;
    mul_e    op;
    jmp_e    jmp;
  } uword_t;

  typedef struct packed {
    uword_t           word;
    logic [OCT_W-1:0] octave;
    logic             busy;
    logic             finish;
  } seq_ctrl_t;

  // One octave: four reads, two horizontal blends, one vertical, weight and sum.
  localparam uword_t UCODE [UCODE_LEN] = '{
    '{rd: CRN_00, ld_s0: 1'b0, op: MUL_NONE, jmp: JMP_NEXT},
    '{rd: CRN_10, ld_s0: 1'b1, op: MUL_NONE, jmp: JMP_NEXT},
    '{rd: CRN_01, ld_s0: 1'b0, op: MUL_TOP,  jmp: JMP_NEXT},
    '{rd: CRN_11, ld_s0: 1'b1, op: MUL_NONE, jmp: JMP_NEXT},
    '{rd: CRN_00, ld_s0: 1'b0, op: MUL_BOT,  jmp: JMP_NEXT},
    '{rd: CRN_00, ld_s0: 1'b0, op: MUL_VERT, jmp: JMP_NEXT},
    '{rd: CRN_00, ld_s0: 1'b0, op: MUL_WGT,  jmp: JMP_OCT}
  };

endpackage

`default_nettype wire

FILE: src/octave_value_noise_2d.sv
// Query: accepted at an edge with start high and busy low; valid_o strobes with the
// result on noise_value_o after seven microcode steps per octave over five octaves,
// bounded by the single seed-memory read port and the one shared multiply-add unit.
// A new query is taken only once busy is low again; a seed write raises no busy.
// Reset restores the default weights and idles the sequencer; seeds are not cleared.
`default_nettype none

module octave_value_noise_2d (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            cmd_i,
  input  wire logic [ovn_pkg::COORD_W-1:0]     x_i,
  input  wire logic [ovn_pkg::COORD_W-1:0]     y_i,
  input  wire logic [ovn_pkg::VAL_W-1:0]       seed_value_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ovn_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ovn_pkg::VAL_W-1:0]       cfg_wdata_i,
  output logic                                 valid_o,
  output logic      [ovn_pkg::VAL_W-1:0]       noise_value_o
);

  localparam int CW = ovn_pkg::COORD_W;
  localparam int VW = ovn_pkg::VAL_W;
  localparam int FW = ovn_pkg::FRAC_W;
  localparam int AW = ovn_pkg::ACC_W;

  ovn_pkg::seq_ctrl_t ctrl;
  logic               accept, go;

  logic [VW-1:0]  weight_q [ovn_pkg::WEIGHT_REGS];
  logic [CW-1:0]  x_q, y_q;
  logic [VW-1:0]  s0_q, top_q, bot_q, v_q;
  logic [AW-1:0]  acc_q, acc_sum;
  logic [VW-1:0]  noise_q;
  logic           valid_q;

  logic [CW:0]    pitch;
  logic [CW-1:0]  mask, sx1, sy1, sx2, sy2, cx, cy;
  logic [FW-1:0]  bx, by;
  logic [VW-1:0]  rdata, weight;

  logic [VW-1:0]        base;
  logic [FW-1:0]        fac;
  logic signed [VW:0]   dlt;
  logic signed [2*VW+1:0] prod;
  logic signed [VW+1:0] msum;
  logic [VW-1:0]        res;

  assign busy   = ctrl.busy;
  assign accept = start && !ctrl.busy;
  assign go     = accept && (cmd_i == ovn_pkg::CMD_QUERY);

  ovn_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .ctrl_o (ctrl)
  );

  // Corner geometry of the current octave
  assign pitch = (CW + 1)'(ovn_pkg::GRID_SIZE) >> ctrl.octave;
  assign mask  = CW'(pitch - 1'b1);
  assign sx1   = x_q & ~mask;
  assign sy1   = y_q & ~mask;
  assign sx2   = sx1 + pitch[CW-1:0];
  assign sy2   = sy1 + pitch[CW-1:0];
  assign bx    = FW'({{(FW - CW){1'b0}}, x_q & mask} << (FW - CW + ctrl.octave));
  assign by    = FW'({{(FW - CW){1'b0}}, y_q & mask} << (FW - CW + ctrl.octave));

  always_comb begin
    unique case (ctrl.word.rd)
      ovn_pkg::CRN_00: begin cx = sx1; cy = sy1; end
      ovn_pkg::CRN_10: begin cx = sx2; cy = sy1; end
      ovn_pkg::CRN_01: begin cx = sx1; cy = sy2; end
      ovn_pkg::CRN_11: begin cx = sx2; cy = sy2; end
      default:         begin cx = sx1; cy = sy1; end
    endcase
  end

  ovn_ram #(
    .WIDTH (VW),
    .DEPTH (ovn_pkg::DEPTH)
  ) u_seed_ram (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd_i == ovn_pkg::CMD_WRITE)),
    .waddr_i ({y_i, x_i}),
    .wdata_i (seed_value_i),
    .raddr_i ({cy, cx}),
    .rdata_o (rdata)
  );

  assign weight = weight_q[ovn_pkg::CFG_IDX_W'(ctrl.octave)];

  // Shared multiply-add: base + (fac * dlt) >>> 16
  always_comb begin
    unique case (ctrl.word.op)
      ovn_pkg::MUL_TOP, ovn_pkg::MUL_BOT: begin
        base = s0_q;
        fac  = bx;
        dlt  = $signed({1'b0, rdata}) - $signed({1'b0, s0_q});
      end
      ovn_pkg::MUL_VERT: begin
        base = top_q;
        fac  = by;
        dlt  = $signed({1'b0, bot_q}) - $signed({1'b0, top_q});
      end
      ovn_pkg::MUL_WGT: begin
        base = '0;
        fac  = weight;
        dlt  = $signed({1'b0, v_q});
      end
      default: begin
        base = '0;
        fac  = '0;
        dlt  = '0;
      end
    endcase
  end

  assign prod    = $signed({1'b0, fac}) * dlt;
  assign msum    = $signed({2'b00, base}) + $signed(prod[2*VW+1:FW]);
  assign res     = msum[VW-1:0];
  assign acc_sum = acc_q + AW'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ovn_pkg::WEIGHT_REGS; i++) begin
        weight_q[i] <= ovn_pkg::WEIGHT_RST[i];
      end
      valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < ovn_pkg::CFG_IDX_W'(ovn_pkg::WEIGHT_REGS))) begin
        weight_q[cfg_idx_i] <= cfg_wdata_i;
      end
      valid_q <= ctrl.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      x_q   <= x_i;
      y_q   <= y_i;
      acc_q <= '0;
    end
    if (ctrl.busy && ctrl.word.ld_s0) begin
      s0_q <= rdata;
    end
    if (ctrl.busy) begin
      unique case (ctrl.word.op)
        ovn_pkg::MUL_TOP:  top_q <= res;
        ovn_pkg::MUL_BOT:  bot_q <= res;
        ovn_pkg::MUL_VERT: v_q   <= res;
        ovn_pkg::MUL_WGT:  acc_q <= acc_sum;
        default: ;
      endcase
    end
    if (ctrl.finish) begin
      noise_q <= (acc_sum > AW'({VW{1'b1}})) ? {VW{1'b1}} : acc_sum[VW-1:0];
    end
  end

  assign valid_o       = valid_q;
  assign noise_value_o = noise_q;

endmodule

`default_nettype wire

FILE: src/ovn_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ovn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: src/ovn_seq.sv
// Microcode sequencer: step counter, octave counter and program table.
// Depends on ovn_pkg.
`default_nettype none

module ovn_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  output ovn_pkg::seq_ctrl_t     ctrl_o
);

  logic [ovn_pkg::STEP_W-1:0] step_q, step_d;
  logic [ovn_pkg::OCT_W-1:0]  octave_q, octave_d;
  logic                       busy_q, busy_d;
  ovn_pkg::uword_t            word;
  logic                       last;

  assign word = ovn_pkg::UCODE[step_q];
  assign last = (octave_q == ovn_pkg::OCT_W'(ovn_pkg::OCTAVE_COUNT - 1));

  always_comb begin
    step_d   = step_q;
    octave_d = octave_q;
    busy_d   = busy_q;
    if (busy_q) begin
      unique case (word.jmp)
        ovn_pkg::JMP_NEXT: begin
          step_d = step_q + 1'b1;
        end
        ovn_pkg::JMP_OCT: begin
          step_d = '0;
          if (last) begin
            busy_d = 1'b0;
          end else begin
            octave_d = octave_q + 1'b1;
          end
        end
        default: begin
          step_d = '0;
        end
      endcase
    end else if (go_i) begin
      busy_d   = 1'b1;
      step_d   = '0;
      octave_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      octave_q <= '0;
      busy_q   <= 1'b0;
    end else begin
      step_q   <= step_d;
      octave_q <= octave_d;
      busy_q   <= busy_d;
    end
  end

  assign ctrl_o.word   = word;
  assign ctrl_o.octave = octave_q;
  assign ctrl_o.busy   = busy_q;
  assign ctrl_o.finish = busy_q && (word.jmp == ovn_pkg::JMP_OCT) && last;

endmodule

`default_nettype wire

FILE: src/ovn_chk.sv
// Port-level checker for octave_value_noise_2d, attached by the bind below.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ovn_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic cmd_i,
  input wire logic valid_o
);

  `OVN_ASSERT_NXT(a_query_busy, clk_i, rst_ni, start && !busy && cmd_i, busy, "query not busy")
  `OVN_ASSERT_NXT(a_write_idle, clk_i, rst_ni, start && !busy && !cmd_i, !busy, "write went busy")
  `OVN_ASSERT_IMP(a_valid_idle, clk_i, rst_ni, valid_o, !busy, "result while busy")
  `OVN_ASSERT_IMP(a_fall_valid, clk_i, rst_ni, $fell(busy), valid_o, "busy fell, no result")
  `OVN_ASSERT_NXT(a_one_beat, clk_i, rst_ni, valid_o, !valid_o, "result longer than a beat")

endmodule

bind octave_value_noise_2d ovn_chk u_ovn_chk (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .cmd_i   (cmd_i),
  .valid_o (valid_o)
);

`default_nettype wire
